// File: hdl/flowtot_pkg.sv
// Shared types and constants for the flow pulse event totalizer.
// Holds the request and response word structs, opcode, link and register codes.
// No dependencies.
`default_nettype none

package flowtot_pkg;

   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   typedef enum logic [1:0] {
      OP_PULSE  = 2'd0,
      OP_TICK   = 2'd1,
      OP_BUTTON = 2'd2
   } opcode_type;

   localparam logic [2:0] LINK_CONNECTED    = 3'd0;
   localparam logic [2:0] LINK_DISCONNECTED = 3'd2;

   localparam logic [1:0] REG_IDLE_SLEEP_LIMIT  = 2'd0;
   localparam logic [1:0] REG_QUIET_TICKS_LIMIT = 2'd1;
   localparam logic [1:0] REG_VOLUME_PER_PULSE  = 2'd2;

   localparam logic [15:0] SLEEP_LIMIT_RESET = 16'd60;
   localparam logic [7:0]  QUIET_LIMIT_RESET = 8'd2;
   localparam logic [31:0] VOL_PER_PULSE_RESET = 32'h0001_0000;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] link_state;
   } req_word_type;

   typedef struct packed {
      logic        is_drinking;
      logic        event_closed;
      logic [15:0] added_volume;
      logic [15:0] total_volume;
      logic [15:0] total_pulses;
      logic [15:0] event_count;
      logic        hibernate_request;
      logic        advertise_request;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: hdl/flow_pulse_event_totalizer.sv
// Top level of the flow pulse event totalizer: input register, event logic, result register.
// Depends on flowtot_pkg.
//
// Usage:
//   req channel (req_valid, req_stall, req_word) carries one event word: hall pulse,
//   one-second tick or button press, plus the radio link state.
//   rsp channel (rsp_valid, rsp_stall, rsp_word) returns exactly one result word per
//   event: drinking flag, close flag, added volume, running totals and requests.
//   csr port is APB-style, always ready: 0x0 sleep limit, 0x4 quiet limit,
//   0x8 volume per pulse (unsigned Q16.16). Write registers only while idle.
// Path: an accepted word passes the input register, then the result register, to rsp_valid.
// Throughput: one word per cycle while no result stalls; the close path (16x32 multiply,
//   saturate, 16-bit add) sits between the input register and the totals registers.
// Reset: synchronous; clears all counters and totals, loads register defaults.
// Stall: a stalled result holds; the input register still takes one more word,
//   then req_stall rises until the result is taken.
`default_nettype none

module flow_pulse_event_totalizer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire flowtot_pkg::req_word_type req_word,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output flowtot_pkg::rsp_word_type      rsp_word,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [flowtot_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [flowtot_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [flowtot_pkg::CsrDataWidth-1:0]      csr_prdata,
   output logic                           csr_pready
);
   import flowtot_pkg::*;

   logic [15:0] sleep_limit_ff;
   logic [7:0]  quiet_limit_ff;
   logic [31:0] vol_per_pulse_ff;

   logic        s1_valid_ff;
   req_word_type s1_word_ff;
   logic        rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;

   logic [15:0] idle_ticks_ff, idle_ticks_in;
   logic        drinking_ff, drinking_in;
   logic [15:0] pending_ff, pending_in;
   logic [15:0] event_pulses_ff, event_pulses_in;
   logic [15:0] volume_total_ff, volume_total_in;
   logic [15:0] pulse_total_ff, pulse_total_in;
   logic [15:0] closed_events_ff, closed_events_in;

   logic        advance;
   logic        fire;
   logic        csr_write;
   logic        closing;
   logic [47:0] product;
   logic [15:0] added_sat;
   logic [15:0] idle_work;
   logic        hib;
   logic        adv;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // csr access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         REG_IDLE_SLEEP_LIMIT:  csr_prdata = {16'd0, sleep_limit_ff};
         REG_QUIET_TICKS_LIMIT: csr_prdata = {24'd0, quiet_limit_ff};
         REG_VOLUME_PER_PULSE:  csr_prdata = vol_per_pulse_ff;
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sleep_limit_ff   <= SLEEP_LIMIT_RESET;
         quiet_limit_ff   <= QUIET_LIMIT_RESET;
         vol_per_pulse_ff <= VOL_PER_PULSE_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_IDLE_SLEEP_LIMIT:  sleep_limit_ff   <= csr_pwdata[15:0];
            REG_QUIET_TICKS_LIMIT: quiet_limit_ff   <= csr_pwdata[7:0];
            REG_VOLUME_PER_PULSE:  vol_per_pulse_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // close volume: only reached without a same-tick merge, so the stored count is exact
   assign product   = {32'd0, event_pulses_ff} * {16'd0, vol_per_pulse_ff};
   assign added_sat = (product[47:32] != 16'd0) ? 16'hFFFF : product[31:16];

   always_comb begin
      pending_in       = pending_ff;
      event_pulses_in  = event_pulses_ff;
      drinking_in      = drinking_ff;
      idle_ticks_in    = idle_ticks_ff;
      volume_total_in  = volume_total_ff;
      pulse_total_in   = pulse_total_ff;
      closed_events_in = closed_events_ff;
      idle_work        = idle_ticks_ff;
      closing          = 1'b0;
      hib              = 1'b0;
      adv              = 1'b0;
      case (s1_word_ff.opcode)
         OP_PULSE: begin
            if (pending_ff != 16'hFFFF) pending_in = pending_ff + 16'd1;
         end
         OP_TICK: begin
            if (pending_ff != 16'd0) begin
               event_pulses_in = event_pulses_ff + pending_ff;
               pending_in      = 16'd0;
               drinking_in     = 1'b1;
               idle_work       = 16'd0;
            end
            closing = (idle_work > {8'd0, quiet_limit_ff}) && drinking_in;
            if (closing) begin
               drinking_in      = 1'b0;
               volume_total_in  = volume_total_ff + added_sat;
               pulse_total_in   = pulse_total_ff + event_pulses_ff;
               closed_events_in = closed_events_ff + 16'd1;
               event_pulses_in  = 16'd0;
            end
            if (s1_word_ff.link_state == LINK_CONNECTED) idle_work = 16'd0;
            hib           = (idle_work == sleep_limit_ff);
            idle_ticks_in = idle_work + 16'd1;
         end
         OP_BUTTON: begin
            idle_ticks_in = 16'd0;
            drinking_in   = 1'b0;
            adv           = (s1_word_ff.link_state == LINK_DISCONNECTED);
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_word_in.is_drinking       = drinking_in;
      rsp_word_in.event_closed      = closing;
      rsp_word_in.added_volume      = closing ? added_sat : 16'd0;
      rsp_word_in.total_volume      = volume_total_in;
      rsp_word_in.total_pulses      = pulse_total_in;
      rsp_word_in.event_count       = closed_events_in;
      rsp_word_in.hibernate_request = hib;
      rsp_word_in.advertise_request = adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         idle_ticks_ff    <= '0;
         drinking_ff      <= 1'b0;
         pending_ff       <= '0;
         event_pulses_ff  <= '0;
         volume_total_ff  <= '0;
         pulse_total_ff   <= '0;
         closed_events_ff <= '0;
      end else begin
         if (!s1_valid_ff || advance) s1_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= s1_valid_ff;
         if (fire) begin
            idle_ticks_ff    <= idle_ticks_in;
            drinking_ff      <= drinking_in;
            pending_ff       <= pending_in;
            event_pulses_ff  <= event_pulses_in;
            volume_total_ff  <= volume_total_in;
            pulse_total_ff   <= pulse_total_in;
            closed_events_ff <= closed_events_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) s1_word_ff <= req_word;
      if (fire) rsp_word_ff <= rsp_word_in;
   end

   a_close_ends_drinking: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_word_ff.event_closed && rsp_word_ff.is_drinking))
      else $error("closed event still marked drinking");

   a_volume_only_on_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.event_closed) |-> (rsp_word_ff.added_volume == 16'd0))
      else $error("added volume without a closed event");

   a_requests_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_word_ff.hibernate_request && rsp_word_ff.advertise_request))
      else $error("hibernate and advertise in one word");

   a_count_advances: assert property (@(posedge clock) disable iff (reset)
      (fire && closing) |=> (closed_events_ff == $past(closed_events_ff) + 16'd1))
      else $error("event count did not advance on close");

   a_idle_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(idle_ticks_ff) && $stable(pending_ff))
      else $error("state changed without an item");

endmodule

`default_nettype wire

// File: tb/tb_flow_pulse_event_totalizer.sv
// Self-checking testbench for flow_pulse_event_totalizer: random and directed event words,
// CSR writes over the APB-style port, and a scoreboard that predicts each result word.
// Depends on flowtot_pkg and the flow_pulse_event_totalizer RTL.
`timescale 1ns / 1ps

module tb_flow_pulse_event_totalizer;
   import flowtot_pkg::*;

   localparam logic [1:0] OP_UNKNOWN        = 2'd3;
   localparam logic [2:0] LINK_ADVERTISING  = 3'd1;
   localparam logic [2:0] LINK_INITIALIZING = 3'd3;
   localparam logic [2:0] LINK_STOPPED      = 3'd4;
   localparam logic [2:0] LINK_UNDEFINED    = 3'd7;
   localparam int unsigned QUIET_CYCLE_LIMIT = 2000;

   class totals_scoreboard;
      bit [15:0] sleep_limit;
      bit [7:0]  quiet_limit;
      bit [31:0] vol_per_pulse;
      bit [15:0] idle_ticks;
      bit        drinking;
      bit [15:0] pending;
      bit [15:0] event_pulses;
      bit [15:0] volume_total;
      bit [15:0] pulse_total;
      bit [15:0] closed_events;
      rsp_word_type expected_words[$];
      int unsigned errors;

      function new();
         sleep_limit   = SLEEP_LIMIT_RESET;
         quiet_limit   = QUIET_LIMIT_RESET;
         vol_per_pulse = VOL_PER_PULSE_RESET;
         idle_ticks    = '0;
         drinking      = 1'b0;
         pending       = '0;
         event_pulses  = '0;
         volume_total  = '0;
         pulse_total   = '0;
         closed_events = '0;
         errors        = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            REG_IDLE_SLEEP_LIMIT:  sleep_limit   = value[15:0];
            REG_QUIET_TICKS_LIMIT: quiet_limit   = value[7:0];
            REG_VOLUME_PER_PULSE:  vol_per_pulse = value;
            default: ;
         endcase
      endfunction

      function void note_event(req_word_type w);
         rsp_word_type r;
         bit [47:0] product;
         bit [31:0] scaled;
         r = '0;
         case (w.opcode)
            OP_PULSE: begin
               if (pending != 16'hFFFF) pending = pending + 16'd1;
            end
            OP_TICK: begin
               if (pending != 16'd0) begin
                  event_pulses = event_pulses + pending;
                  pending      = '0;
                  drinking     = 1'b1;
                  idle_ticks   = '0;
               end
               if (idle_ticks > {8'd0, quiet_limit} && drinking) begin
                  product = 48'(event_pulses) * 48'(vol_per_pulse);
                  scaled  = product[47:16];
                  r.added_volume = (scaled > 32'h0000_FFFF) ? 16'hFFFF : scaled[15:0];
                  drinking       = 1'b0;
                  volume_total   = volume_total + r.added_volume;
                  pulse_total    = pulse_total + event_pulses;
                  closed_events  = closed_events + 16'd1;
                  event_pulses   = '0;
                  r.event_closed = 1'b1;
               end
               if (w.link_state == LINK_CONNECTED) idle_ticks = '0;
               r.hibernate_request = (idle_ticks == sleep_limit);
               idle_ticks = idle_ticks + 16'd1;
            end
            OP_BUTTON: begin
               idle_ticks = '0;
               drinking   = 1'b0;
               r.advertise_request = (w.link_state == LINK_DISCONNECTED);
            end
            default: ;
         endcase
         r.is_drinking  = drinking;
         r.total_volume = volume_total;
         r.total_pulses = pulse_total;
         r.event_count  = closed_events;
         expected_words.push_back(r);
      endfunction

      function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            $error("result word with no expectation waiting: %h", got);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         compare_field("is_drinking", 16'(want.is_drinking), 16'(got.is_drinking));
         compare_field("event_closed", 16'(want.event_closed), 16'(got.event_closed));
         compare_field("added_volume", want.added_volume, got.added_volume);
         compare_field("total_volume", want.total_volume, got.total_volume);
         compare_field("total_pulses", want.total_pulses, got.total_pulses);
         compare_field("event_count", want.event_count, got.event_count);
         compare_field("hibernate_request", 16'(want.hibernate_request),
                       16'(got.hibernate_request));
         compare_field("advertise_request", 16'(want.advertise_request),
                       16'(got.advertise_request));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic csr_pready;

   totals_scoreboard sb;
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   int unsigned quiet_cycles = 0;

   flow_pulse_event_totalizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_word);
      rsp_stall <= recv_idle_on && ($urandom_range(99) < 32);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_CYCLE_LIMIT) begin
         $display("flow_pulse_event_totalizer regression: fail");
         $finish;
      end
   end

   task automatic send_event(logic [1:0] op, logic [2:0] link);
      req_word_type w;
      w.opcode     = op;
      w.link_state = link;
      while (send_idle_on && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sb.note_event(w);
   endtask

   task automatic send_run(logic [1:0] op, int unsigned count, logic [2:0] link);
      repeat (count) send_event(op, link);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.write_reg(index, value);
   endtask

   task automatic set_config(logic [15:0] sleep, logic [7:0] quiet, logic [31:0] vpp);
      wait_drained();
      csr_write(REG_IDLE_SLEEP_LIMIT, {16'h0000, sleep});
      csr_write(REG_QUIET_TICKS_LIMIT, {24'h000000, quiet});
      csr_write(REG_VOLUME_PER_PULSE, vpp);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic random_phase(int unsigned word_goal, logic [7:0] quiet);
      int unsigned sent;
      int unsigned burst;
      int unsigned k;
      logic [2:0] link;
      sent = 0;
      while (sent < word_goal) begin
         if ($urandom_range(99) < 75) begin
            burst = $urandom_range(1, 6);
            for (k = 0; k < burst; k++) send_event(OP_PULSE, 3'($urandom_range(0, 7)));
            sent += burst;
            burst = $urandom_range(1, int'(quiet) + 3);
            for (k = 0; k < burst; k++) begin
               link = ($urandom_range(99) < 15) ? LINK_CONNECTED : 3'($urandom_range(1, 7));
               send_event(OP_TICK, link);
            end
            sent += burst;
            if ($urandom_range(99) < 20) begin
               send_event(OP_BUTTON, 3'($urandom_range(0, 7)));
               sent++;
            end
         end else begin
            send_event(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            sent++;
         end
         if ($urandom_range(99) < 3) wait_drained();
      end
   endtask

   initial begin
      int unsigned i;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // default registers: close, button paths, unknown opcode and link codes
      send_run(OP_PULSE, 3, LINK_ADVERTISING);
      send_run(OP_TICK, 4, LINK_STOPPED);
      send_event(OP_BUTTON, LINK_DISCONNECTED);
      send_event(OP_BUTTON, LINK_CONNECTED);
      send_event(OP_TICK, LINK_CONNECTED);
      send_event(OP_UNKNOWN, LINK_UNDEFINED);
      send_event(OP_PULSE, LINK_UNDEFINED);
      send_event(OP_TICK, 3'd5);
      send_event(OP_BUTTON, 3'd6);
      send_event(OP_PULSE, LINK_INITIALIZING);
      send_run(OP_TICK, 4, LINK_INITIALIZING);

      // zero limits, full-scale factor: saturated volume, hibernate at zero
      set_config(16'h0000, 8'h00, 32'hFFFF_FFFF);
      for (i = 0; i < 2; i++) begin
         send_run(OP_PULSE, 2, LINK_STOPPED);
         send_event(OP_TICK, LINK_CONNECTED);
         send_event(OP_TICK, LINK_INITIALIZING);
      end

      // top limits, zero factor
      set_config(16'hFFFF, 8'hFF, 32'h0000_0000);
      send_event(OP_PULSE, LINK_STOPPED);
      send_run(OP_TICK, 20, LINK_ADVERTISING);

      // long stretch with no idling on either side
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      set_config(16'd4, 8'd2, VOL_PER_PULSE_RESET);
      random_phase(80, 8'd2);
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;

      set_config(16'd5, 8'd1, $urandom());
      random_phase(80, 8'd1);
      set_config(16'd3, 8'd0, 32'hFFFF_FFFF);
      random_phase(80, 8'd0);
      for (i = 0; i < 2; i++) begin
         set_config(16'($urandom_range(0, 12)), 8'($urandom_range(0, 4)),
                    (i == 1) ? $urandom() : 32'($urandom_range(0, 32'h0004_0000)));
         random_phase(80, sb.quiet_limit);
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.expected_words.size() != 0) begin
         $error("%0d expected result words never arrived", sb.expected_words.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("flow_pulse_event_totalizer regression: pass");
      end else begin
         $display("flow_pulse_event_totalizer regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/flowtot_pkg.sv
hdl/flow_pulse_event_totalizer.sv
tb/tb_flow_pulse_event_totalizer.sv
